// File: sv/crcpf_pkg.sv
// ----------------------------------------------------------------------------
// CRC-16 packet framer package
// Shared types, register indexes, byte kinds and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
`default_nettype none

package crcpf_pkg;

  localparam int unsigned CfgIdxWidth  = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] REG_HDR_FIRST  = 2'd0;
  localparam logic [CfgIdxWidth-1:0] REG_HDR_SECOND = 2'd1;
  localparam logic [CfgIdxWidth-1:0] REG_MAX_LEN    = 2'd2;

  localparam logic [7:0]  HDR_FIRST_RESET  = 8'h55;
  localparam logic [7:0]  HDR_SECOND_RESET = 8'hAA;
  localparam logic [15:0] MAX_LEN_RESET    = 16'd256;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_DATA  = 1'b1;

  typedef enum logic [1:0] {
    KIND_DATA,
    KIND_CRC_LO,
    KIND_CRC_HI
  } byte_kind_e;

  typedef struct packed {
    logic [7:0]  header_first_byte;
    logic [7:0]  header_second_byte;
    logic [15:0] max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic        func;
    logic [7:0]  payload_byte;
    logic [15:0] timestamp;
    logic [15:0] length;
  } in_item_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: sv/crcpf_if.sv
// ----------------------------------------------------------------------------
// CRC-16 packet framer channels
// Valid/ready channels for input items and for frame words.
// ----------------------------------------------------------------------------
`default_nettype none

interface crcpf_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [7:0]  payload_byte;
  logic [15:0] timestamp;
  logic [15:0] length;

  modport source (output valid, func, payload_byte, timestamp, length, input ready);
  modport sink   (input valid, func, payload_byte, timestamp, length, output ready);
endinterface

interface crcpf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       end_of_run;
  logic       end_of_frame;

  modport source (output valid, out_byte, end_of_run, end_of_frame, input ready);
  modport sink   (input valid, out_byte, end_of_run, end_of_frame, output ready);
endinterface

`default_nettype wire

// File: sv/crcpf_cfg_regs.sv
// ----------------------------------------------------------------------------
// CRC-16 packet framer configuration registers
// Header bytes and payload length limit, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_cfg_regs import crcpf_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  output cfg_t                         cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_HDR_FIRST:  cfg_d.header_first_byte  = cfg_data_i[7:0];
        REG_HDR_SECOND: cfg_d.header_second_byte = cfg_data_i[7:0];
        REG_MAX_LEN:    cfg_d.max_payload_length = cfg_data_i[15:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_first_byte  <= HDR_FIRST_RESET;
      cfg_q.header_second_byte <= HDR_SECOND_RESET;
      cfg_q.max_payload_length <= MAX_LEN_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: sv/crcpf_in_reg.sv
// ----------------------------------------------------------------------------
// CRC-16 packet framer input register
// Holds one accepted item until the framer has produced all of its words.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_in_reg import crcpf_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  crcpf_in_if.sink   in_s,
  output in_item_t   item_o,
  output logic       item_vld_o,
  input  wire logic  consume_i
);

  in_item_t item_q;
  logic     vld_q, vld_d;
  logic     accept;

  assign in_s.ready = !vld_q || consume_i;
  assign accept     = in_s.valid && in_s.ready;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (consume_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.func         <= in_s.func;
      item_q.payload_byte <= in_s.payload_byte;
      item_q.timestamp    <= in_s.timestamp;
      item_q.length       <= in_s.length;
    end
  end

  assign item_o     = item_q;
  assign item_vld_o = vld_q;

endmodule

`default_nettype wire

// File: sv/crcpf_framer.sv
// ----------------------------------------------------------------------------
// CRC-16 packet framer core
// Walks the words of the held item, updates the running CRC and loads the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_framer import crcpf_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire cfg_t      cfg_i,
  input  wire in_item_t  item_i,
  input  wire logic      item_vld_i,
  output logic           consume_o,
  crcpf_out_if.source    out_m
);

  logic [2:0]  idx_q, idx_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] rem_q, rem_d;
  logic        in_frame_q, in_frame_d;
  logic        out_vld_q, out_vld_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        eor_q, eor_d;
  logic        eof_q, eof_d;

  logic        out_free;
  logic        is_start;
  logic        first;
  logic        drop;
  logic        last_data;
  logic        eor;
  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [15:0] rem_dec;
  logic [7:0]  data_byte;
  logic [7:0]  byte_val;
  byte_kind_e  kind;

  always_comb begin
    out_free = !out_vld_q || out_m.ready;
    is_start = item_i.func == FUNC_START;
    first    = idx_q == 3'd0;
    crc_base = (is_start && first) ? CRC_INIT : crc_q;
    rem_dec  = rem_q - 16'd1;
    drop     = first && (is_start ? (item_i.length > cfg_i.max_payload_length)
                                  : !in_frame_q);

    if (is_start) begin
      unique case (idx_q)
        3'd0:    data_byte = cfg_i.header_first_byte;
        3'd1:    data_byte = cfg_i.header_second_byte;
        3'd2:    data_byte = item_i.timestamp[7:0];
        3'd3:    data_byte = item_i.timestamp[15:8];
        3'd4:    data_byte = item_i.length[7:0];
        3'd5:    data_byte = item_i.length[15:8];
        default: data_byte = 8'h00;
      endcase
      if (idx_q == 3'd6) begin
        kind = KIND_CRC_LO;
      end else if (idx_q == 3'd7) begin
        kind = KIND_CRC_HI;
      end else begin
        kind = KIND_DATA;
      end
      last_data = (idx_q == 3'd5) && (item_i.length != 16'd0);
    end else begin
      data_byte = item_i.payload_byte;
      if (idx_q == 3'd0) begin
        kind = KIND_DATA;
      end else if (idx_q == 3'd1) begin
        kind = KIND_CRC_LO;
      end else begin
        kind = KIND_CRC_HI;
      end
      last_data = rem_dec != 16'd0;
    end

    crc_next = crc_byte(crc_base, data_byte);

    unique case (kind)
      KIND_DATA:   byte_val = data_byte;
      KIND_CRC_LO: byte_val = crc_q[7:0];
      KIND_CRC_HI: byte_val = crc_q[15:8];
      default:     byte_val = data_byte;
    endcase

    eor = (kind == KIND_CRC_HI) || ((kind == KIND_DATA) && last_data);
  end

  always_comb begin
    idx_d      = idx_q;
    crc_d      = crc_q;
    rem_d      = rem_q;
    in_frame_d = in_frame_q;
    out_vld_d  = out_vld_q && !out_m.ready;
    out_byte_d = out_byte_q;
    eor_d      = eor_q;
    eof_d      = eof_q;
    consume_o  = 1'b0;

    if (item_vld_i && out_free) begin
      if (drop) begin
        consume_o = 1'b1;
        if (is_start) begin
          in_frame_d = 1'b0;
          rem_d      = 16'd0;
          crc_d      = CRC_INIT;
        end
      end else begin
        out_vld_d  = 1'b1;
        out_byte_d = byte_val;
        eor_d      = eor;
        eof_d      = kind == KIND_CRC_HI;
        idx_d      = eor ? 3'd0 : idx_q + 3'd1;
        consume_o  = eor;
        unique case (kind)
          KIND_DATA: begin
            crc_d = crc_next;
            if (is_start) begin
              if (first) begin
                in_frame_d = 1'b0;
                rem_d      = 16'd0;
              end
              if (last_data) begin
                in_frame_d = 1'b1;
                rem_d      = item_i.length;
              end
            end else begin
              rem_d = rem_dec;
            end
          end
          KIND_CRC_HI: begin
            in_frame_d = 1'b0;
            rem_d      = 16'd0;
            crc_d      = CRC_INIT;
          end
          default: begin
            crc_d = crc_q;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= 3'd0;
      crc_q      <= CRC_INIT;
      rem_q      <= 16'd0;
      in_frame_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      idx_q      <= idx_d;
      crc_q      <= crc_d;
      rem_q      <= rem_d;
      in_frame_q <= in_frame_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    eor_q      <= eor_d;
    eof_q      <= eof_d;
  end

  assign out_m.valid        = out_vld_q;
  assign out_m.out_byte     = out_byte_q;
  assign out_m.end_of_run   = eor_q;
  assign out_m.end_of_frame = eof_q;

endmodule

`default_nettype wire

// File: sv/crc16_packet_framer.sv
// ----------------------------------------------------------------------------
// CRC-16 packet framer
// Builds serial frames word by word: header, timestamp, length, payload and a
// CRC-16/MODBUS trailer.
// ----------------------------------------------------------------------------
// Items enter on in_s: a start item (func 0) carries a timestamp and a payload
// length, a data item (func 1) carries one payload byte. Frame words leave on
// out_m, one per handshake; end_of_run marks the last word caused by an item
// and end_of_frame marks the CRC high byte that closes a frame.
// An accepted item sits in an input register; its first word is then loaded
// into the output register, which drives out_m. The core produces one word per
// cycle while the receiver is ready, so a data item inside a frame gives one
// word, the last data item of a frame three, a start item six, or eight for an
// empty payload. Starts longer than the limit and data items outside a frame
// produce no words. A new item is accepted in the cycle its predecessor issues
// its last word. When the receiver stalls, the output word holds and the input
// register fills, after which in_s.ready falls. Reset clears both registers'
// valid flags, closes any open frame and loads the register defaults. The user
// must write configuration only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_packet_framer import crcpf_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  wire logic [CfgDataWidth-1:0] cfg_data_i,
  crcpf_in_if.sink                     in_s,
  crcpf_out_if.source                  out_m
);

  cfg_t     cfg;
  in_item_t item;
  logic     item_vld;
  logic     consume;

  crcpf_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  crcpf_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_s       (in_s),
    .item_o     (item),
    .item_vld_o (item_vld),
    .consume_i  (consume)
  );

  crcpf_framer u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .item_i     (item),
    .item_vld_i (item_vld),
    .consume_o  (consume),
    .out_m      (out_m)
  );

endmodule

`default_nettype wire

// File: sv/crcpf_checker.sv
// ----------------------------------------------------------------------------
// CRC-16 packet framer checker
// Port-level assertions on the frame word stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module crcpf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic [7:0] out_byte_i,
  input wire logic       out_eor_i,
  input wire logic       out_eof_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) && $stable(out_eor_i)
                                    && $stable(out_eof_i))
    else $error("stalled frame word changed");

  a_eof_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_eof_i |-> out_eor_i)
    else $error("frame end without end of run");

  a_no_double_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_eof_i |=> !(out_valid_i && out_eof_i))
    else $error("two frame ends in a row");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_i)
    else $error("frame word present right after reset");

endmodule

bind crc16_packet_framer crcpf_checker u_crcpf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_m.valid),
  .out_ready_i (out_m.ready),
  .out_byte_i  (out_m.out_byte),
  .out_eor_i   (out_m.end_of_run),
  .out_eof_i   (out_m.end_of_frame)
);

`default_nettype wire
